FILE: hw/rtl/tpe_pkg.sv
// shared types, constants and helpers of the triangle plane unit
package tpe_pkg;

	localparam int COORD_W   = 32;
	localparam int EDGE_W    = COORD_W + 1;
	localparam int CMAG_W    = 63;
	localparam int UNORM_W   = 31;
	localparam int SUM_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int REM_W     = 36;
	localparam int QUO_W     = 31;
	localparam int DVD_W     = 62;
	localparam int DREM_W    = 33;
	localparam int NORM_MSB  = 30;
	localparam int ROUND_SH  = 30;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]  edge_t;

	// payload that rides along the normalize, root and divide stages
	typedef struct packed {
		logic [2:0][UNORM_W-1:0] u;
		logic [2:0]              neg;
		logic [2:0][COORD_W-1:0] p0;
		logic                    deg;
	} pay_t;

	function automatic logic [EDGE_W-1:0] edge_mag(edge_t v);
		logic [EDGE_W-1:0] m;
		m = v[EDGE_W-1] ? (~v + EDGE_W'(1)) : v;
		return m;
	endfunction

	// magnitude shift toward zero, sign kept
	function automatic coord_t reduce_comp(edge_t v, logic [1:0] s);
		logic [EDGE_W-1:0] sh;
		sh = edge_mag(v) >> s;
		return v[EDGE_W-1] ? coord_t'(32'd0 - sh[COORD_W-1:0]) : coord_t'(sh[COORD_W-1:0]);
	endfunction

endpackage

FILE: hw/rtl/triangle_plane_equation.sv
// triangle plane unit: unit normal and offset of a triangle, fully pipelined
//
// takes one triangle per beat (three points, signed q16.16) and returns one
// beat with the unit normal in q1.30, the offset d = -(n . p0) in q16.16
// rounded half away from zero and saturated, and flags for a degenerate
// triangle and a clipped offset. a new triangle can enter on every clock
// unless the pipe is frozen; the integer square root takes 32 steps and the
// three parallel normal dividers take 31 steps, each one register
// stage. the whole pipe moves as one: it freezes only while a finished beat
// sits in the output register with plane_stall high, so tri_stall follows
// that condition directly and nothing is dropped or repeated. a degenerate
// triangle (cross product of zero) returns zero normal, zero offset and
// degenerate set. there is no configuration and no state between beats.
module triangle_plane_equation (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tri_valid,
	output logic            tri_stall,
	input  tpe_pkg::coord_t p0_x,
	input  tpe_pkg::coord_t p0_y,
	input  tpe_pkg::coord_t p0_z,
	input  tpe_pkg::coord_t p1_x,
	input  tpe_pkg::coord_t p1_y,
	input  tpe_pkg::coord_t p1_z,
	input  tpe_pkg::coord_t p2_x,
	input  tpe_pkg::coord_t p2_y,
	input  tpe_pkg::coord_t p2_z,
	output logic            plane_valid,
	input  logic            plane_stall,
	output tpe_pkg::coord_t normal_x,
	output tpe_pkg::coord_t normal_y,
	output tpe_pkg::coord_t normal_z,
	output tpe_pkg::coord_t plane_offset,
	output logic            degenerate,
	output logic            saturated
);
	import tpe_pkg::*;

	// global advance: the pipe moves unless the output beat is held
	logic adv;
	assign adv       = !(plane_valid && plane_stall);
	assign tri_stall = !adv;

	coord_t p0_in [3];
	coord_t p1_in [3];
	coord_t p2_in [3];
	assign p0_in = '{p0_x, p0_y, p0_z};
	assign p1_in = '{p1_x, p1_y, p1_z};
	assign p2_in = '{p2_x, p2_y, p2_z};

	// s1: edge vectors
	logic   v_s1;
	coord_t p0_s1 [3];
	edge_t  e1_s1 [3];
	edge_t  e2_s1 [3];
	// s2: reduced edges
	logic   v_s2;
	coord_t p0_s2 [3];
	coord_t e1_s2 [3];
	coord_t e2_s2 [3];
	// s3: partial products of the cross product
	logic               v_s3;
	coord_t             p0_s3 [3];
	logic signed [63:0] pr_s3 [6];
	// s4: cross product magnitudes and signs
	logic              v_s4;
	coord_t            p0_s4 [3];
	logic [CMAG_W-1:0] u_s4 [3];
	logic [2:0]        neg_s4;
	// s5: or of magnitudes for the leading-one search
	logic              v_s5;
	coord_t            p0_s5 [3];
	logic [CMAG_W-1:0] u_s5 [3];
	logic [2:0]        neg_s5;
	logic [CMAG_W-1:0] orv_s5;
	// s6: highest nonzero byte
	logic              v_s6;
	coord_t            p0_s6 [3];
	logic [CMAG_W-1:0] u_s6 [3];
	logic [2:0]        neg_s6;
	logic [2:0]        grp_s6;
	logic [7:0]        byte_s6;
	logic              deg_s6;
	// s7: leading one position
	logic              v_s7;
	coord_t            p0_s7 [3];
	logic [CMAG_W-1:0] u_s7 [3];
	logic [2:0]        neg_s7;
	logic [5:0]        pos_s7;
	logic              deg_s7;
	// s8: normalized magnitudes
	logic v_s8;
	pay_t pay_s8;
	// s9: squares
	logic                v_s9;
	pay_t                pay_s9;
	logic [2*UNORM_W-1:0] sq_s9 [3];
	// s10: sum of squares
	logic             v_s10;
	pay_t             pay_s10;
	logic [SUM_W-1:0] sum_s10;

	// s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s1  <= tri_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p0_s1[i] <= p0_in[i];
				e1_s1[i] <= edge_t'(p1_in[i]) - edge_t'(p0_in[i]);
				e2_s1[i] <= edge_t'(p2_in[i]) - edge_t'(p0_in[i]);
			end
		end
	end

	// s2: shift each edge so all its components fit 32 bits
	logic [EDGE_W-1:0] or1, or2;
	logic [1:0]        sh1, sh2;
	always_comb begin
		or1 = edge_mag(e1_s1[0]) | edge_mag(e1_s1[1]) | edge_mag(e1_s1[2]);
		or2 = edge_mag(e2_s1[0]) | edge_mag(e2_s1[1]) | edge_mag(e2_s1[2]);
		sh1 = or1[EDGE_W-1] ? 2'd2 : (or1[EDGE_W-2] ? 2'd1 : 2'd0);
		sh2 = or2[EDGE_W-1] ? 2'd2 : (or2[EDGE_W-2] ? 2'd1 : 2'd0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p0_s2[i] <= p0_s1[i];
				e1_s2[i] <= reduce_comp(e1_s1[i], sh1);
				e2_s2[i] <= reduce_comp(e2_s1[i], sh2);
			end
		end
	end

	// s3: six products
	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s3    <= p0_s2;
			pr_s3[0] <= 64'(e1_s2[1]) * 64'(e2_s2[2]);
			pr_s3[1] <= 64'(e1_s2[2]) * 64'(e2_s2[1]);
			pr_s3[2] <= 64'(e1_s2[2]) * 64'(e2_s2[0]);
			pr_s3[3] <= 64'(e1_s2[0]) * 64'(e2_s2[2]);
			pr_s3[4] <= 64'(e1_s2[0]) * 64'(e2_s2[1]);
			pr_s3[5] <= 64'(e1_s2[1]) * 64'(e2_s2[0]);
		end
	end

	// s4: cross product, split into magnitude and sign
	logic signed [63:0] c4 [3];
	logic [63:0]        m4 [3];
	always_comb begin
		c4[0] = pr_s3[0] - pr_s3[1];
		c4[1] = pr_s3[2] - pr_s3[3];
		c4[2] = pr_s3[4] - pr_s3[5];
		for (int i = 0; i < 3; i++) begin
			m4[i] = c4[i][63] ? 64'(-c4[i]) : 64'(c4[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s4 <= p0_s3;
			for (int i = 0; i < 3; i++) begin
				u_s4[i]   <= m4[i][CMAG_W-1:0];
				neg_s4[i] <= c4[i][63];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s5  <= p0_s4;
			u_s5   <= u_s4;
			neg_s5 <= neg_s4;
			orv_s5 <= u_s4[0] | u_s4[1] | u_s4[2];
		end
	end

	// s6: coarse leading-one search by byte
	logic [63:0] pad6;
	logic [2:0]  grp6;
	always_comb begin
		pad6 = {1'b0, orv_s5};
		grp6 = 3'd0;
		for (int g = 0; g < 8; g++) begin
			if (pad6[8*g +: 8] != 8'd0) grp6 = 3'(g);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s6   <= p0_s5;
			u_s6    <= u_s5;
			neg_s6  <= neg_s5;
			grp_s6  <= grp6;
			byte_s6 <= pad6[8*grp6 +: 8];
			deg_s6  <= (orv_s5 == '0);
		end
	end

	// s7: fine search inside the byte
	logic [2:0] bit7;
	always_comb begin
		bit7 = 3'd0;
		for (int b = 0; b < 8; b++) begin
			if (byte_s6[b]) bit7 = 3'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s7  <= p0_s6;
			u_s7   <= u_s6;
			neg_s7 <= neg_s6;
			pos_s7 <= {grp_s6, bit7};
			deg_s7 <= deg_s6;
		end
	end

	// s8: block shift that puts the largest magnitude's top bit at bit 30
	logic [CMAG_W-1:0] n8 [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s7 > 6'(NORM_MSB)) begin
				n8[i] = u_s7[i] >> (pos_s7 - 6'(NORM_MSB));
			end else begin
				n8[i] = u_s7[i] << (6'(NORM_MSB) - pos_s7);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pay_s8.u[i]  <= n8[i][UNORM_W-1:0];
				pay_s8.p0[i] <= p0_s7[i];
			end
			pay_s8.neg <= neg_s7;
			pay_s8.deg <= deg_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s9 <= pay_s8;
			for (int i = 0; i < 3; i++) begin
				sq_s9[i] <= pay_s8.u[i] * pay_s8.u[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s10 <= pay_s9;
			sum_s10 <= SUM_W'(sq_s9[0]) + SUM_W'(sq_s9[1]) + SUM_W'(sq_s9[2]);
		end
	end

	// integer square root, one result bit per stage; index 0 is the s10 input
	logic              sqrt_v_s   [ROOT_W+1];
	logic [REM_W-1:0]  sqrt_rem_s [ROOT_W+1];
	logic [ROOT_W-1:0] sqrt_root_s[ROOT_W+1];
	logic [SUM_W-1:0]  sqrt_x_s   [ROOT_W+1];
	pay_t              sqrt_pay_s [ROOT_W+1];

	assign sqrt_v_s[0]    = v_s10;
	assign sqrt_rem_s[0]  = '0;
	assign sqrt_root_s[0] = '0;
	assign sqrt_x_s[0]    = sum_s10;
	assign sqrt_pay_s[0]  = pay_s10;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		localparam int BI = ROOT_W - 1 - j;
		logic [REM_W-1:0] rem_in, trial;
		logic             ge;
		always_comb begin
			rem_in = {sqrt_rem_s[j][REM_W-3:0], sqrt_x_s[j][2*BI+1 -: 2]};
			trial  = REM_W'({sqrt_root_s[j], 2'b01});
			ge     = (rem_in >= trial);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqrt_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				sqrt_v_s[j+1] <= sqrt_v_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sqrt_rem_s[j+1]  <= ge ? (rem_in - trial) : rem_in;
				sqrt_root_s[j+1] <= {sqrt_root_s[j][ROOT_W-2:0], ge};
				sqrt_x_s[j+1]    <= sqrt_x_s[j];
				sqrt_pay_s[j+1]  <= sqrt_pay_s[j];
			end
		end
	end

	// dividend with half the length added for rounding
	logic              v_sd;
	pay_t              pay_sd;
	logic [ROOT_W-1:0] len_sd;
	logic [DVD_W-1:0]  dvd_sd [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
		end else if (adv) begin
			v_sd <= sqrt_v_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_sd <= sqrt_pay_s[ROOT_W];
			len_sd <= sqrt_root_s[ROOT_W];
			for (int i = 0; i < 3; i++) begin
				dvd_sd[i] <= DVD_W'({sqrt_pay_s[ROOT_W].u[i], 30'd0})
					+ DVD_W'(sqrt_root_s[ROOT_W][ROOT_W-1:1]);
			end
		end
	end

	// three restoring dividers in lockstep, one quotient bit per stage
	logic              div_v_s   [QUO_W+1];
	pay_t              div_pay_s [QUO_W+1];
	logic [ROOT_W-1:0] div_len_s [QUO_W+1];
	logic [DVD_W-1:0]  div_dvd_s [QUO_W+1][3];
	logic [DREM_W-1:0] div_rem_s [QUO_W+1][3];
	logic [QUO_W-1:0]  div_quo_s [QUO_W+1][3];

	assign div_v_s[0]   = v_sd;
	assign div_pay_s[0] = pay_sd;
	assign div_len_s[0] = len_sd;
	for (genvar l = 0; l < 3; l++) begin : g_div_init
		assign div_dvd_s[0][l] = dvd_sd[l];
		assign div_rem_s[0][l] = DREM_W'(dvd_sd[l][DVD_W-1:QUO_W]);
		assign div_quo_s[0][l] = '0;
	end

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int KB = QUO_W - 1 - j;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				div_v_s[j+1] <= div_v_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_pay_s[j+1] <= div_pay_s[j];
				div_len_s[j+1] <= div_len_s[j];
			end
		end
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DREM_W-1:0] rin;
			logic              ge;
			always_comb begin
				rin = {div_rem_s[j][l][DREM_W-2:0], div_dvd_s[j][l][KB]};
				ge  = (rin >= DREM_W'(div_len_s[j]));
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					div_dvd_s[j+1][l] <= div_dvd_s[j][l];
					div_rem_s[j+1][l] <= ge ? (rin - DREM_W'(div_len_s[j])) : rin;
					div_quo_s[j+1][l] <= {div_quo_s[j][l][QUO_W-2:0], ge};
				end
			end
		end
	end

	// signed normal, products with p0, dot sum
	logic   v_sn, v_sp, v_sa;
	coord_t n_sn  [3];
	coord_t p0_sn [3];
	logic   deg_sn, deg_sp, deg_sa;
	logic signed [63:0] pr_sp [3];
	coord_t             n_sp  [3];
	coord_t             n_sa  [3];
	logic signed [63:0] dot_sa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn        <= 1'b0;
			v_sp        <= 1'b0;
			v_sa        <= 1'b0;
			plane_valid <= 1'b0;
		end else if (adv) begin
			v_sn        <= div_v_s[QUO_W];
			v_sp        <= v_sn;
			v_sa        <= v_sp;
			plane_valid <= v_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_sn <= div_pay_s[QUO_W].deg;
			for (int i = 0; i < 3; i++) begin
				p0_sn[i] <= coord_t'(div_pay_s[QUO_W].p0[i]);
				if (div_pay_s[QUO_W].deg) begin
					n_sn[i] <= '0;
				end else if (div_pay_s[QUO_W].neg[i]) begin
					n_sn[i] <= coord_t'(32'd0 - COORD_W'(div_quo_s[QUO_W][i]));
				end else begin
					n_sn[i] <= coord_t'(div_quo_s[QUO_W][i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_sp <= deg_sn;
			n_sp   <= n_sn;
			for (int i = 0; i < 3; i++) begin
				pr_sp[i] <= 64'(n_sn[i]) * 64'(p0_sn[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_sa <= deg_sp;
			n_sa   <= n_sp;
			dot_sa <= pr_sp[0] + pr_sp[1] + pr_sp[2];
		end
	end

	// negate, round half away from zero dropping 30 bits, saturate
	logic signed [63:0] negd;
	logic [63:0]        mag, rsum;
	logic [33:0]        rq;
	coord_t             d_val;
	logic               sat_val;
	always_comb begin
		negd    = -dot_sa;
		mag     = negd[63] ? 64'(-negd) : 64'(negd);
		rsum    = mag + (64'd1 << (ROUND_SH - 1));
		rq      = rsum[ROUND_SH +: 34];
		sat_val = 1'b0;
		if (negd[63]) begin
			if (rq > 34'h0_8000_0000) begin
				d_val   = coord_t'(32'h8000_0000);
				sat_val = 1'b1;
			end else begin
				d_val = coord_t'(32'd0 - rq[31:0]);
			end
		end else begin
			if (rq > 34'h0_7fff_ffff) begin
				d_val   = coord_t'(32'h7fff_ffff);
				sat_val = 1'b1;
			end else begin
				d_val = coord_t'(rq[31:0]);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			normal_x     <= n_sa[0];
			normal_y     <= n_sa[1];
			normal_z     <= n_sa[2];
			plane_offset <= deg_sa ? '0 : d_val;
			saturated    <= deg_sa ? 1'b0 : sat_val;
			degenerate   <= deg_sa;
		end
	end

	// a degenerate beat carries an all-zero plane
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		plane_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0
			&& plane_offset == 0 && !saturated)
		else $error("degenerate beat with nonzero plane");

	// unit normal components stay within one in q1.30
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		plane_valid |-> normal_x <= 32'sh4000_0000 && normal_x >= -32'sh4000_0000
			&& normal_y <= 32'sh4000_0000 && normal_y >= -32'sh4000_0000
			&& normal_z <= 32'sh4000_0000 && normal_z >= -32'sh4000_0000)
		else $error("normal component out of range");

	// a clipped offset sits at one of the range limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		plane_valid && saturated |-> plane_offset == 32'sh7fff_ffff
			|| plane_offset == -32'sh8000_0000)
		else $error("saturated offset not at a limit");

	// a held output beat keeps the whole pipe frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plane_valid && plane_stall |=> plane_valid && $stable(v_sa))
		else $error("pipe moved while output held");

endmodule
